>>> rtl/u8d_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the UTF-8 byte stream decoder.
// No dependencies; every other file refers to it by scoped names.
package u8d_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CP_W        = 21;
  localparam int unsigned REM_W       = 2;
  localparam int unsigned CONT_BITS   = 6;
  localparam int unsigned LEAD2_BITS  = 5;
  localparam int unsigned LEAD3_BITS  = 4;
  localparam int unsigned LEAD4_BITS  = 3;
  localparam int unsigned ASCII_BITS  = 7;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  typedef enum logic [2:0] {
    KIND_ASCII,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_OTHER
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [BYTE_W-1:0]  data;
    logic               last;
  } item_t;

endpackage

>>> rtl/u8d_in_if.sv
`timescale 1ns / 1ps
// Input byte channel: valid/ready handshake with one byte and an end-of-string flag.
// Depends on u8d_pkg for field widths.
interface u8d_in_if;
  logic                         valid;
  logic                         ready;
  logic [u8d_pkg::BYTE_W-1:0]   byte_in;
  logic                         string_end;

  modport source (output valid, output byte_in, output string_end, input ready);
  modport sink   (input valid, input byte_in, input string_end, output ready);
endinterface

>>> rtl/u8d_out_if.sv
`timescale 1ns / 1ps
// Output code point channel: valid/ready handshake with a 21-bit code point.
// Depends on u8d_pkg for field widths.
interface u8d_out_if;
  logic                       valid;
  logic                       ready;
  logic [u8d_pkg::CP_W-1:0]   code_point;
  logic                       from_final_byte;

  modport source (output valid, output code_point, output from_final_byte, input ready);
  modport sink   (input valid, input code_point, input from_final_byte, output ready);
endinterface

>>> rtl/u8d_front.sv
`timescale 1ns / 1ps
// Front end: accept input bytes and tag each as ASCII, lead byte or other.
// Depends on u8d_pkg and u8d_in_if.
module u8d_front (
  u8d_in_if.sink          in_i,
  output logic            push_valid_o,
  output u8d_pkg::item_t  push_item_o,
  input  logic            push_ready_i
);

  u8d_pkg::kind_e kind;

  always_comb begin
    if (in_i.byte_in[7] == 1'b0) begin
      kind = u8d_pkg::KIND_ASCII;
    end else if (in_i.byte_in[7:5] == u8d_pkg::LEAD2_TAG) begin
      kind = u8d_pkg::KIND_LEAD2;
    end else if (in_i.byte_in[7:4] == u8d_pkg::LEAD3_TAG) begin
      kind = u8d_pkg::KIND_LEAD3;
    end else if (in_i.byte_in[7:3] == u8d_pkg::LEAD4_TAG) begin
      kind = u8d_pkg::KIND_LEAD4;
    end else begin
      kind = u8d_pkg::KIND_OTHER;
    end
  end

  assign in_i.ready        = push_ready_i;
  assign push_valid_o      = in_i.valid;
  assign push_item_o.kind  = kind;
  assign push_item_o.data  = in_i.byte_in;
  assign push_item_o.last  = in_i.string_end;

endmodule

>>> rtl/u8d_queue.sv
`timescale 1ns / 1ps
// Small FIFO of tagged items between front and back end.
// Depends on u8d_pkg. Depth must be at least 2.
module u8d_queue #(
  parameter int unsigned Depth = u8d_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  u8d_pkg::item_t  push_item_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output u8d_pkg::item_t  pop_item_o,
  input  logic            pop_ready_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  u8d_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> rtl/u8d_back.sv
`timescale 1ns / 1ps
// Back end: sequence state, code point assembly and the output register.
// Depends on u8d_pkg and u8d_out_if.
module u8d_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  input  u8d_pkg::item_t  pop_item_i,
  output logic            pop_ready_o,
  u8d_out_if.source       out_o
);

  logic [u8d_pkg::REM_W-1:0] rem_q, rem_d;
  logic [u8d_pkg::CP_W-1:0]  pv_q, pv_d;
  logic [u8d_pkg::CP_W-1:0]  acc;
  logic [u8d_pkg::CP_W-1:0]  cp_q, cp_d;
  logic                      last_q;
  logic                      out_valid_q, out_valid_d;
  logic                      pop, emit;

  assign pop_ready_o = !out_valid_q || out_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;
  assign acc         = {pv_q[u8d_pkg::CP_W-u8d_pkg::CONT_BITS-1:0],
                        pop_item_i.data[u8d_pkg::CONT_BITS-1:0]};

  always_comb begin
    rem_d = rem_q;
    pv_d  = pv_q;
    emit  = 1'b0;
    cp_d  = cp_q;
    if (pop) begin
      if (rem_q != '0) begin
        rem_d = rem_q - u8d_pkg::REM_W'(1);
        if (rem_q == u8d_pkg::REM_W'(1)) begin
          emit = 1'b1;
          cp_d = acc;
          pv_d = '0;
        end else begin
          pv_d = acc;
        end
      end else begin
        case (pop_item_i.kind)
          u8d_pkg::KIND_ASCII: begin
            emit = 1'b1;
            cp_d = u8d_pkg::CP_W'(pop_item_i.data[u8d_pkg::ASCII_BITS-1:0]);
          end
          u8d_pkg::KIND_LEAD2: begin
            pv_d  = u8d_pkg::CP_W'(pop_item_i.data[u8d_pkg::LEAD2_BITS-1:0]);
            rem_d = u8d_pkg::REM_W'(1);
          end
          u8d_pkg::KIND_LEAD3: begin
            pv_d  = u8d_pkg::CP_W'(pop_item_i.data[u8d_pkg::LEAD3_BITS-1:0]);
            rem_d = u8d_pkg::REM_W'(2);
          end
          u8d_pkg::KIND_LEAD4: begin
            pv_d  = u8d_pkg::CP_W'(pop_item_i.data[u8d_pkg::LEAD4_BITS-1:0]);
            rem_d = u8d_pkg::REM_W'(3);
          end
          default: begin
          end
        endcase
      end
      // drop an unfinished sequence at end of string
      if (pop_item_i.last && rem_d != '0) begin
        rem_d = '0;
        pv_d  = '0;
      end
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      pv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      cp_q   <= cp_d;
      last_q <= pop_item_i.last;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.code_point      = cp_q;
  assign out_o.from_final_byte = last_q;

endmodule

>>> rtl/utf8_byte_stream_decoder.sv
`timescale 1ns / 1ps
// UTF-8 byte stream decoder: bytes in, 21-bit code points out.
// Throughput: one byte per cycle, sustained, with the output ready.
// The final byte of a sequence is written into the item queue; the back end pops it and
// loads the code point into the output register, which drives the output valid.
// Reset: asynchronous, active low; clears sequence state, queue and output valid.
module utf8_byte_stream_decoder #(
  parameter int unsigned QueueDepth = u8d_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  u8d_in_if.sink     in_i,
  u8d_out_if.source  out_o
);

  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;
  u8d_pkg::item_t push_item, pop_item;

  u8d_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  u8d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  u8d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule
